// ===== src/ldsl_pkg.sv =====
// Package: shared constants, types and codes for the link deletion slot lookup.
package ldsl_pkg;
    localparam int MAX_LINKS_DEF      = 1024;
    localparam int SLOTS_PER_LINK_DEF = 16;

    localparam logic [1:0] CMD_CLEAR  = 2'd0;
    localparam logic [1:0] CMD_INSERT = 2'd1;
    localparam logic [1:0] CMD_QUERY  = 2'd2;
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    localparam logic REG_NUM_LINKS = 1'b0;
    localparam logic REG_SLOT_LEN  = 1'b1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CNT,
        S_DIV,
        S_SRCH_RD,
        S_SRCH_CMP,
        S_INS_RD,
        S_INS_CMP,
        S_DONE
    } t_state;
endpackage

// ===== src/ldsl_ram.sv =====
// Generic single-port synchronous RAM with registered read.
module ldsl_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule

// ===== src/ldsl_div.sv =====
// Iterative restoring divider, one quotient bit per cycle.
module ldsl_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [31:0] i_num,
    input  logic [31:0] i_den,
    output logic        o_done,
    output logic [31:0] o_quot
);
    logic [31:0] r_q, n_q;
    logic [32:0] r_rem, n_rem;
    logic [31:0] r_den;
    logic [5:0]  r_cnt;
    logic        r_busy;
    logic [32:0] w_trial;

    // one shift-subtract step
    always_comb begin
        w_trial = {r_rem[31:0], r_q[31]};
        n_q     = {r_q[30:0], 1'b0};
        n_rem   = w_trial;
        if (w_trial >= {1'b0, r_den}) begin
            n_rem   = w_trial - {1'b0, r_den};
            n_q[0]  = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= 6'd0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 6'd1;
            if (r_cnt == 6'd31) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_num;
            r_rem <= '0;
            r_den <= (i_den == 32'd0) ? 32'd1 : i_den;
        end else if (r_busy) begin
            r_q   <= n_q;
            r_rem <= n_rem;
        end
    end

    assign o_done = r_busy && (r_cnt == 6'd31);
    assign o_quot = n_q;
endmodule

// ===== src/link_deletion_slot_lookup.sv =====
// Top level: per-link sorted deletion-slot lists with insert, clear and query.
// One command is handled at a time; when it finishes, its result is loaded
// into the output register. Clear, an out-of-range link and the unused command
// go straight to the finishing state; an insert first reads the list count and
// stops there if the list is full. A query reads the count, runs the bit-serial
// divider and then a binary search with one slot-memory read per probe (at most
// 5 probes for 16 entries). An insert shifts larger entries up with one read and
// one write-back of the slot memory per shifted entry, then writes the new slot
// and the new count. The output register lets the next command be accepted
// while a result waits; that command holds in its finishing cycle until the
// waiting result is taken. Slot and count memories are single-ported RAMs;
// counts are reset by a sweep over all MAX_LINKS entries after reset, during
// which no command is accepted.
module link_deletion_slot_lookup import ldsl_pkg::*; #(
    parameter int MAX_LINKS      = MAX_LINKS_DEF,
    parameter int SLOTS_PER_LINK = SLOTS_PER_LINK_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_cmd,
    input  logic [9:0]  i_link,
    input  logic [31:0] i_value,
    output logic        o_valid,
    input  logic        i_ready,
    output logic        o_deleted,
    output logic [1:0]  o_status,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [0:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);
    localparam int LW = (MAX_LINKS > 1) ? $clog2(MAX_LINKS) : 1;
    localparam int SW = (SLOTS_PER_LINK > 1) ? $clog2(SLOTS_PER_LINK) : 1;
    localparam int CW = $clog2(SLOTS_PER_LINK + 1);
    localparam int AW = $clog2(MAX_LINKS * SLOTS_PER_LINK);

    // configuration registers
    logic [10:0] r_num_links;
    logic [31:0] r_slot_len;
    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_links <= '0;
            r_slot_len  <= 32'd1;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_NUM_LINKS: r_num_links <= i_cfg_data[10:0];
                REG_SLOT_LEN:  r_slot_len  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    t_state r_state, n_state;
    logic          r_sweep;
    logic [LW:0]   r_swp_cnt;
    logic [1:0]    r_cmd;
    logic [LW-1:0] r_link;
    logic [31:0]   r_key;
    logic [CW-1:0] r_n, r_lo, r_hi, r_i;
    logic          r_out_v, r_del;
    logic [1:0]    r_st;
    logic          r_out_del;
    logic [1:0]    r_out_st;

    // memories
    logic          c_we, s_we;
    logic [LW-1:0] c_addr;
    logic [CW-1:0] c_wd, c_rd;
    logic [AW-1:0] s_addr;
    logic [31:0]   s_wd, s_rd;

    ldsl_ram #(.WIDTH(CW), .DEPTH(MAX_LINKS)) u_cnt (
        .i_clk(i_clk), .i_we(c_we), .i_addr(c_addr), .i_wdata(c_wd), .o_rdata(c_rd));
    ldsl_ram #(.WIDTH(32), .DEPTH(MAX_LINKS * SLOTS_PER_LINK)) u_slot (
        .i_clk(i_clk), .i_we(s_we), .i_addr(s_addr), .i_wdata(s_wd), .o_rdata(s_rd));

    logic        div_start, div_done;
    logic [31:0] div_q;
    ldsl_div u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(div_start), .i_num(r_key),
        .i_den(r_slot_len), .o_done(div_done), .o_quot(div_q));

    logic          w_acc, w_inr, w_out_free;
    logic [CW-1:0] w_mid;
    logic [CW-1:0] w_im1;
    assign o_ready    = (r_state == S_IDLE) && !r_sweep;
    assign w_acc      = i_valid && o_ready;
    assign w_out_free = !r_out_v || i_ready;
    assign w_inr      = ({1'b0, i_link} < r_num_links) &&
                        ({1'b0, i_link} < 11'(MAX_LINKS));
    assign w_mid      = r_lo + ((r_hi - r_lo) >> 1);
    assign w_im1      = r_i - CW'(1);

    function automatic logic [AW-1:0] addr_of(input logic [LW-1:0] l, input logic [CW-1:0] k);
        addr_of = AW'(l) * AW'(SLOTS_PER_LINK) + AW'(k);
    endfunction

    // sequencer: next state and memory controls
    always_comb begin
        n_state   = r_state;
        c_we      = 1'b0;
        c_addr    = r_link;
        c_wd      = '0;
        s_we      = 1'b0;
        s_addr    = addr_of(r_link, w_mid);
        s_wd      = r_key;
        div_start = 1'b0;
        if (r_sweep) begin
            c_we   = 1'b1;
            c_addr = r_swp_cnt[LW-1:0];
        end
        case (r_state)
            S_IDLE: begin
                if (w_acc) begin
                    n_state = S_DONE;
                    if (w_inr && i_cmd != CMD_UNUSED) begin
                        c_addr = i_link[LW-1:0];
                        if (i_cmd == CMD_CLEAR) begin
                            c_we = 1'b1;
                        end else begin
                            n_state = S_CNT;
                        end
                    end
                end
            end
            S_CNT: begin
                if (r_cmd == CMD_QUERY) begin
                    div_start = 1'b1;
                    n_state   = S_DIV;
                end else if (c_rd >= CW'(SLOTS_PER_LINK)) begin
                    n_state = S_DONE;
                end else begin
                    n_state = S_INS_RD;
                end
            end
            S_DIV: if (div_done) n_state = S_SRCH_RD;
            S_SRCH_RD: begin
                n_state = (r_lo < r_hi) ? S_SRCH_CMP : S_DONE;
            end
            S_SRCH_CMP: begin
                n_state = (s_rd == r_key) ? S_DONE : S_SRCH_RD;
            end
            S_INS_RD: begin
                s_addr = addr_of(r_link, w_im1);
                if (r_i == '0) begin
                    s_we    = 1'b1;
                    s_addr  = addr_of(r_link, r_i);
                    c_we    = 1'b1;
                    c_wd    = r_n + CW'(1);
                    n_state = S_DONE;
                end else begin
                    n_state = S_INS_CMP;
                end
            end
            S_INS_CMP: begin
                s_we   = 1'b1;
                s_addr = addr_of(r_link, r_i);
                if (s_rd > r_key) begin
                    s_wd    = s_rd;
                    n_state = S_INS_RD;
                end else begin
                    c_we    = 1'b1;
                    c_wd    = r_n + CW'(1);
                    n_state = S_DONE;
                end
            end
            // wait here while the previous result still sits in the output register
            S_DONE:  if (w_out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_sweep   <= 1'b1;
            r_swp_cnt <= '0;
            r_out_v   <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_sweep) begin
                r_swp_cnt <= r_swp_cnt + 1'b1;
                if (r_swp_cnt == (LW+1)'(MAX_LINKS - 1)) r_sweep <= 1'b0;
            end
            if (o_valid && i_ready) r_out_v <= 1'b0;
            if (r_state == S_DONE && w_out_free) r_out_v <= 1'b1;
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_cmd  <= i_cmd;
            r_link <= i_link[LW-1:0];
            r_key  <= i_value;
            r_del  <= 1'b0;
            r_st   <= (i_cmd != CMD_UNUSED && !w_inr) ? ST_RANGE : ST_OK;
        end
        // output register loads the finished result
        if (r_state == S_DONE && w_out_free) begin
            r_out_del <= r_del;
            r_out_st  <= r_st;
        end
        case (r_state)
            S_CNT: begin
                r_n  <= c_rd;
                r_i  <= c_rd;
                r_lo <= '0;
                r_hi <= (c_rd > CW'(SLOTS_PER_LINK)) ? CW'(SLOTS_PER_LINK) : c_rd;
                if (r_cmd == CMD_INSERT && c_rd >= CW'(SLOTS_PER_LINK)) r_st <= ST_FULL;
            end
            S_DIV: if (div_done) r_key <= div_q;
            S_SRCH_CMP: begin
                if (s_rd == r_key) r_del <= 1'b1;
                else if (s_rd < r_key) r_lo <= w_mid + CW'(1);
                else r_hi <= w_mid;
            end
            S_INS_CMP: if (s_rd > r_key) r_i <= w_im1;
            default: ;
        endcase
    end

    assign o_valid   = r_out_v;
    assign o_deleted = r_out_del;
    assign o_status  = r_out_st;
endmodule

// ===== test/link_deletion_slot_lookup_tb.sv =====
// Testbench: checks command results of the link deletion slot lookup against a slot list model.
module link_deletion_slot_lookup_tb import ldsl_pkg::*; ();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NLINK = MAX_LINKS_DEF;
    localparam int NSLOT = SLOTS_PER_LINK_DEF;

    // Slot list scoreboard: keeps its own copy of the lists and the registers
    class slot_list_board;
        logic [31:0] slots[NLINK][NSLOT];
        int unsigned counts[NLINK];
        logic [10:0] links_in_use;
        logic [31:0] slot_len;
        logic        exp_deleted[$];
        logic [1:0]  exp_status[$];
        int          mismatches;

        function new();
            foreach (counts[i]) counts[i] = 0;
            links_in_use = '0;
            slot_len = 32'd1;
            mismatches = 0;
        endfunction

        function void write_reg(logic idx, logic [31:0] data);
            if (idx == REG_NUM_LINKS) links_in_use = data[10:0];
            else slot_len = data;
        endfunction

        // Note an accepted command and work out its answer
        function void note_command(logic [1:0] cmd, logic [9:0] lnk, logic [31:0] val);
            logic        del;
            logic [1:0]  st;
            logic [31:0] key;
            logic [31:0] div;
            int          lo, hi, mid, i, n;
            del = 1'b0;
            st = ST_OK;
            if (cmd == CMD_CLEAR || cmd == CMD_INSERT || cmd == CMD_QUERY) begin
                if ({1'b0, lnk} >= links_in_use) begin
                    st = ST_RANGE;
                end else if (cmd == CMD_CLEAR) begin
                    counts[lnk] = 0;
                end else if (cmd == CMD_INSERT) begin
                    n = counts[lnk];
                    if (n >= NSLOT) begin
                        st = ST_FULL;
                    end else begin
                        i = n;
                        while (i > 0 && slots[lnk][i-1] > val) begin
                            slots[lnk][i] = slots[lnk][i-1];
                            i--;
                        end
                        slots[lnk][i] = val;
                        counts[lnk] = n + 1;
                    end
                end else begin
                    div = (slot_len == 0) ? 32'd1 : slot_len;
                    key = val / div;
                    lo = 0;
                    hi = counts[lnk];
                    while (lo < hi && !del) begin
                        mid = lo + (hi - lo) / 2;
                        if (slots[lnk][mid] == key) del = 1'b1;
                        else if (slots[lnk][mid] < key) lo = mid + 1;
                        else hi = mid;
                    end
                end
            end
            exp_deleted.push_back(del);
            exp_status.push_back(st);
        endfunction

        function void check_answer(logic del, logic [1:0] st);
            logic       ed;
            logic [1:0] es;
            if (exp_status.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: deleted %0d status %0d", del, st);
                return;
            end
            ed = exp_deleted.pop_front();
            es = exp_status.pop_front();
            if (ed !== del || es !== st) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: expected deleted %0d status %0d, got %0d %0d",
                             ed, es, del, st);
            end
        endfunction
    endclass

    logic        i_clk, i_rst_n;
    logic        i_valid, o_ready;
    logic [1:0]  i_cmd;
    logic [9:0]  i_link;
    logic [31:0] i_value;
    logic        o_valid, i_ready, o_deleted;
    logic [1:0]  o_status;
    logic        i_cfg_valid, o_cfg_ready;
    logic [0:0]  i_cfg_index;
    logic [31:0] i_cfg_data;

    slot_list_board board;
    bit  calm;           // stretch with no idling on either side
    bit  hold_results;   // long receiver hold-off
    longint cycles;

    link_deletion_slot_lookup DUT (.*);

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        cycles = 0;
        forever begin
            @(posedge i_clk);
            cycles++;
            if (cycles > 64'd3_000_000) begin
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    // Result side: random stalls, check on every transfer
    initial begin
        i_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_valid && i_ready) board.check_answer(o_deleted, o_status);
            i_ready <= !hold_results && (calm || $urandom_range(99) >= 9);
        end
    end

    task automatic write_reg(logic idx, logic [31:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        board.write_reg(idx, data);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // One command transfer, with occasional idle cycles before it;
    // valid stays up after the transfer so the next command can follow at once
    task automatic send(logic [1:0] cmd, logic [9:0] lnk, logic [31:0] val);
        while (!calm && $urandom_range(99) < 9) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_cmd   <= cmd;
        i_link  <= lnk;
        i_value <= val;
        do @(posedge i_clk); while (!o_ready);
        board.note_command(cmd, lnk, val);
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (board.exp_status.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
    endtask

    function automatic logic [31:0] rand_word();
        case ($urandom_range(3))
            0: return 32'($urandom_range(40));
            1: return 32'hFFFF_FFFF - 32'($urandom_range(3));
            default: return $urandom;
        endcase
    endfunction

    // A pick of links: mostly a few busy ones so lists fill up
    function automatic logic [9:0] pick_link(int lim);
        if ($urandom_range(9) == 0) return 10'($urandom);
        if (lim <= 0) return 10'($urandom_range(7));
        return 10'($urandom_range((lim < 6 ? lim : 6) - 1) + ((lim > 900 && $urandom_range(1))
                                                               ? lim - 6 : 0));
    endfunction

    // Random phase: inserts of mostly small slots, queries near them, some clears and unused commands
    task automatic random_phase(int count, int lim);
        logic [31:0] sl;
        logic [9:0]  l;
        int          r;
        sl = board.slot_len;
        for (int k = 0; k < count; k++) begin
            l = pick_link(lim);
            r = $urandom_range(99);
            if (r < 40) send(CMD_INSERT, l, $urandom_range(12) == 0 ? rand_word()
                                                               : $urandom_range(30));
            else if (r < 90) send(CMD_QUERY, l, $urandom_range(9) == 0 ? rand_word()
                         : $urandom_range(30) * (sl == 0 ? 1 : sl) + $urandom_range(2));
            else if (r < 97) send(CMD_CLEAR, l, $urandom);
            else send(CMD_UNUSED, l, $urandom);
        end
    endtask

    initial begin
        board = new();
        calm = 1'b0;
        hold_results = 1'b0;
        i_valid <= 1'b0;
        i_cmd <= CMD_CLEAR;
        i_link <= '0;
        i_value <= '0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= REG_NUM_LINKS;
        i_cfg_data <= '0;
        i_rst_n <= 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: reset limit of zero links, then extremes
        send(CMD_QUERY, 10'd0, 32'd0);
        drain();
        write_reg(REG_NUM_LINKS, 32'd1024);
        write_reg(REG_SLOT_LEN, 32'd0);
        send(CMD_QUERY, 10'd1023, 32'd5);
        send(CMD_INSERT, 10'd1023, 32'd5);
        send(CMD_QUERY, 10'd1023, 32'd5);
        send(CMD_QUERY, 10'd1023, 32'd4);
        send(CMD_INSERT, 10'd1023, 32'hFFFF_FFFF);
        send(CMD_INSERT, 10'd1023, 32'd0);
        send(CMD_INSERT, 10'd1023, 32'd5);
        send(CMD_QUERY, 10'd1023, 32'hFFFF_FFFF);
        for (int k = 0; k < 13; k++) send(CMD_INSERT, 10'd1023, 32'd7);
        send(CMD_INSERT, 10'd1023, 32'd1);
        send(CMD_QUERY, 10'd1023, 32'd7);
        send(CMD_UNUSED, 10'd1023, 32'd7);
        send(CMD_CLEAR, 10'd1023, 32'd0);
        send(CMD_QUERY, 10'd1023, 32'd5);
        drain();

        write_reg(REG_NUM_LINKS, 32'd5);
        write_reg(REG_SLOT_LEN, 32'hFFFF_FFFF);
        send(CMD_INSERT, 10'd0, 32'd1);
        send(CMD_QUERY, 10'd0, 32'hFFFF_FFFF);
        send(CMD_QUERY, 10'd5, 32'd0);
        drain();

        // Receiver holds off while commands keep coming
        write_reg(REG_SLOT_LEN, 32'd3);
        fork
            begin
                hold_results = 1'b1;
                repeat (400) @(posedge i_clk);
                hold_results = 1'b0;
            end
            random_phase(20, 5);
        join
        drain();

        calm = 1'b1;
        random_phase(120, 5);
        calm = 1'b0;
        drain();

        write_reg(REG_NUM_LINKS, 32'd1000);
        write_reg(REG_SLOT_LEN, 32'd1);
        random_phase(180, 1000);
        drain();

        write_reg(REG_NUM_LINKS, 32'd0);
        write_reg(REG_SLOT_LEN, 32'd0);
        random_phase(10, 0);
        drain();
        write_reg(REG_NUM_LINKS, 32'd1024);
        write_reg(REG_SLOT_LEN, 32'd7);
        random_phase(150, 1024);
        drain();

        if (board.mismatches == 0 && board.exp_status.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end
endmodule
